### hdl/nge_pkg.sv
// Shared types, constants and constant functions for the noise gate expander.
// Used by the serial multiplier, the top level and the testbench.
// No dependencies.
package nge_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int ENV_FLOOR       = 21;
  localparam int DB_MIN_Q8       = -25600;
  localparam int DB_PER_LOG2_Q16 = 394566;
  localparam int LOG2_PER_DB_Q24 = 2786635;
  localparam int UNITY_GAIN      = 65536;

  // Register reset values
  localparam logic        BYPASS_RST    = 1'b0;
  localparam logic [1:0]  CHAN_USED_RST = 2'd2;
  localparam logic [15:0] ATTACK_RST    = 16'd65400;
  localparam logic [15:0] RELEASE_RST   = 16'd65522;
  localparam logic [31:0] THR_LVL_RST   = 32'd21474836;
  localparam logic [15:0] THR_DB_RST    = 16'hD800;
  localparam logic [15:0] SLOPE_RST     = 16'd49152;

  // Multiplier lengths in bits of the multiplier operand
  localparam logic [5:0] NB_ENV  = 6'd16;
  localparam logic [5:0] NB_SQR  = 6'd32;
  localparam logic [5:0] NB_DB   = 6'd19;
  localparam logic [5:0] NB_RED  = 6'd16;
  localparam logic [5:0] NB_EXP  = 6'd22;
  localparam logic [5:0] NB_GMUL = 6'd31;
  localparam logic [5:0] NB_GAIN = 6'd17;

  typedef enum logic [2:0] {
    CFG_BYPASS    = 3'd0,
    CFG_CHAN_USED = 3'd1,
    CFG_ATTACK    = 3'd2,
    CFG_RELEASE   = 3'd3,
    CFG_THR_LVL   = 3'd4,
    CFG_THR_DB    = 3'd5,
    CFG_SLOPE     = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV,
    ST_NORM,
    ST_SQR,
    ST_DB,
    ST_RED,
    ST_EXP,
    ST_FRAC,
    ST_GMUL,
    ST_GSHIFT,
    ST_OUT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    logic [5:0] nbits;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_rsp_t;

  // Integer square root, bit by bit; evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] bit_v;
    r     = '0;
    x     = v;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + bit_v) begin
        x = x - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // Root table entry k: 2^30 * 2^(2^-k), floored at every step
  function automatic logic [63:0] exp_rom_calc(input int k);
    logic [63:0] rom;
    rom = 64'd1 << 31;
    for (int j = 1; j <= k; j++) begin
      rom = isqrt64(rom << 30);
    end
    return rom;
  endfunction

endpackage

### hdl/nge_in_if.sv
// Input channel: one stereo frame word with valid/ready handshake.
// Depends on nothing.
interface nge_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_0;
  logic signed [SAMPLE_BITS-1:0] sample_1;

  modport source (output valid, output sample_0, output sample_1, input ready);
  modport sink   (input valid, input sample_0, input sample_1, output ready);
endinterface

### hdl/nge_out_if.sv
// Result channel: scaled frame word plus applied gain, valid/ready handshake.
// Depends on nothing.
interface nge_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample_0;
  logic signed [SAMPLE_BITS-1:0] out_sample_1;
  logic [16:0]                   applied_gain;

  modport source (output valid, output out_sample_0, output out_sample_1,
                  output applied_gain, input ready);
  modport sink   (input valid, input out_sample_0, input out_sample_1,
                  input applied_gain, output ready);
endinterface

### hdl/nge_serial_mult.sv
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
// Depends on nge_pkg.
module nge_serial_mult (
  input  logic               clk,
  input  logic               rst_n,
  input  nge_pkg::mul_req_t  req,
  input  logic signed [63:0] op_a,
  input  logic [31:0]        op_b,
  output nge_pkg::mul_rsp_t  rsp,
  output logic signed [63:0] prod
);
  import nge_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [5:0]         cnt_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] ma_r;
  logic [31:0]        mb_r;

  // Control: count down one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: add shifted multiplicand where the multiplier bit is set
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      ma_r  <= op_a;
      mb_r  <= op_b;
    end else if (busy_r) begin
      if (mb_r[0]) begin
        acc_r <= acc_r + ma_r;
      end
      ma_r <= ma_r <<< 1;
      mb_r <= mb_r >> 1;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign prod     = acc_r;
endmodule

### hdl/noise_gate_expander_unit.sv
// Top level of the noise gate / downward expander.
// Depends on nge_pkg, nge_in_if, nge_out_if and nge_serial_mult.
//
// Usage: frames enter on in_word (sample_0, sample_1) and leave on out_word
// (out_sample_0, out_sample_1, applied_gain), both valid/ready. Registers are
// written through cfg_we / cfg_index / cfg_data; the user must write them only
// while the block is idle, as the block does not enforce this. One frame is
// processed at a time; in_word.ready is high only when idle. All multiplications
// run through one bit-serial multiplier, one multiplier bit per cycle, so the
// time from input accept to output accept depends on the path:
//   bypass: no multiplier products;
//   gated or unity gain: the envelope product, then one product per active channel;
//   expansion: dominated by 16 log squarings and up to 16 root-table products.
// A finished word sits in the output register while the next frame is
// accepted; the block holds in its last state only when that register is
// still full. Reset (rst_n low, synchronous) clears the envelope to zero,
// loads the register defaults and empties the output register.
module noise_gate_expander_unit #(
  parameter int CHANNELS    = nge_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = nge_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  nge_in_if.sink      in_word,
  nge_out_if.source   out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import nge_pkg::*;

  localparam int SB = SAMPLE_BITS;

  // Configuration registers
  logic               bypass_r;
  logic [1:0]         chan_used_r;
  logic [15:0]        attack_r;
  logic [15:0]        release_r;
  logic [31:0]        thr_lvl_r;
  logic signed [15:0] thr_db_r;
  logic [15:0]        slope_r;

  // Control and state
  state_t      state_r, state_nxt;
  logic        pend_r;
  logic [31:0] env_r;
  logic        oval_r;

  // Work registers
  logic signed [SB-1:0] s0_r, s1_r, o0_r, o1_r, os0_r, os1_r;
  logic [31:0]          peak_r, y_r, g_r;
  logic [4:0]           p_r, k_r;
  logic signed [22:0]   l2_r;
  logic [3:0]           it_r;
  logic signed [17:0]   diff_r, red_r;
  logic [5:0]           n_r, sh_r;
  logic [15:0]          f_r;
  logic [16:0]          gain_r, ogain_r;
  logic                 ch_r;

  // Multiplier hookup
  mul_req_t           mul_req;
  mul_rsp_t           mul_rsp;
  logic signed [63:0] mul_a, prod;
  logic [31:0]        mul_b;
  logic               step;

  logic [30:0] rom_tab [16];

  for (genvar k = 0; k < 16; k++) begin : g_rom
    localparam logic [63:0] RV = exp_rom_calc(k + 1);
    assign rom_tab[k] = RV[30:0];
  end

  nge_serial_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .rsp   (mul_rsp),
    .prod  (prod)
  );

  // Derived values
  logic                 accept, two_ch, load_out;
  logic [SB-1:0]        abs0, abs1;
  logic [31:0]          mag0, mag1, peak_in;
  logic [32:0]          env_diff;
  logic [31:0]          env_new, sqr_t, g_new;
  logic signed [24:0]   db_raw;
  logic signed [17:0]   db_val, diff_new, red_new;
  logic signed [23:0]   e_new;
  logic signed [7:0]    e_hi;
  logic [5:0]           pm;
  logic signed [SB-1:0] o_new;

  assign accept   = in_word.valid && in_word.ready;
  assign two_ch   = (CHANNELS >= 2) && (chan_used_r >= 2'd2);
  assign load_out = (state_r == ST_DONE) && (!oval_r || out_word.ready);
  assign step     = pend_r && mul_rsp.done;

  // Peak magnitude of the arriving frame, Q1.31
  assign abs0    = in_word.sample_0[SB-1] ? SB'(-in_word.sample_0) : SB'(in_word.sample_0);
  assign abs1    = in_word.sample_1[SB-1] ? SB'(-in_word.sample_1) : SB'(in_word.sample_1);
  assign mag0    = 32'(abs0) << (32 - SB);
  assign mag1    = two_ch ? (32'(abs1) << (32 - SB)) : 32'd0;
  assign peak_in = (mag1 > mag0) ? mag1 : mag0;

  assign env_diff = {1'b0, env_r} - {1'b0, peak_r};
  assign env_new  = peak_r + prod[47:16];
  assign sqr_t    = prod[61:30];
  assign g_new    = prod[61:30];
  assign db_raw   = prod[48:24];
  assign db_val   = (db_raw < 25'(DB_MIN_Q8)) ? 18'(DB_MIN_Q8) : 18'(db_raw);
  assign diff_new = db_val - 18'(thr_db_r);
  assign red_new  = prod[33:16];
  assign e_new    = prod[39:16];
  assign e_hi     = e_new[23:16];
  assign pm       = {1'b0, p_r} - 6'd31;
  assign o_new    = prod[16+SB-1:16];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = bypass_r ? ST_DONE : ST_ENV;
      ST_ENV: begin
        if (step) begin
          if (env_new <= 32'(ENV_FLOOR))  state_nxt = ST_OUT;
          else if (env_new < thr_lvl_r)   state_nxt = ST_NORM;
          else                            state_nxt = ST_OUT;
        end
      end
      ST_NORM:   if (y_r[31]) state_nxt = ST_SQR;
      ST_SQR:    if (step && it_r == 4'd0) state_nxt = ST_DB;
      ST_DB:     if (step) state_nxt = ST_RED;
      ST_RED:    if (step) state_nxt = (red_new <= 18'(DB_MIN_Q8)) ? ST_OUT : ST_EXP;
      ST_EXP:    if (step) state_nxt = (e_new >= 0) ? ST_OUT : ST_FRAC;
      ST_FRAC: begin
        if (k_r == 5'd16)  state_nxt = ST_GSHIFT;
        else if (f_r[15])  state_nxt = ST_GMUL;
      end
      ST_GMUL:   if (step) state_nxt = ST_FRAC;
      ST_GSHIFT: if (sh_r == 6'd0) state_nxt = ST_OUT;
      ST_OUT:    if (step && (ch_r || !two_ch)) state_nxt = ST_DONE;
      ST_DONE:   if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operands per state
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.nbits = NB_ENV;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      ST_ENV: begin
        mul_req.start = !pend_r;
        mul_a = 64'($signed(env_diff));
        mul_b = 32'((peak_r > env_r) ? attack_r : release_r);
      end
      ST_SQR: begin
        mul_req.start = !pend_r;
        mul_req.nbits = NB_SQR;
        mul_a = {32'd0, y_r};
        mul_b = y_r;
      end
      ST_DB: begin
        mul_req.start = !pend_r;
        mul_req.nbits = NB_DB;
        mul_a = 64'(l2_r);
        mul_b = 32'(DB_PER_LOG2_Q16);
      end
      ST_RED: begin
        mul_req.start = !pend_r;
        mul_req.nbits = NB_RED;
        mul_a = 64'(diff_r);
        mul_b = 32'(slope_r);
      end
      ST_EXP: begin
        mul_req.start = !pend_r;
        mul_req.nbits = NB_EXP;
        mul_a = 64'(red_r);
        mul_b = 32'(LOG2_PER_DB_Q24);
      end
      ST_GMUL: begin
        mul_req.start = !pend_r;
        mul_req.nbits = NB_GMUL;
        mul_a = {32'd0, g_r};
        mul_b = 32'(rom_tab[k_r[3:0]]);
      end
      ST_OUT: begin
        mul_req.start = !pend_r;
        mul_req.nbits = NB_GAIN;
        mul_a = ch_r ? 64'(s1_r) : 64'(s0_r);
        mul_b = 32'(gain_r);
      end
      default: mul_req.start = 1'b0;
    endcase
  end

  // Control registers, configuration and envelope
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      env_r       <= '0;
      oval_r      <= 1'b0;
      bypass_r    <= BYPASS_RST;
      chan_used_r <= CHAN_USED_RST;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
      thr_lvl_r   <= THR_LVL_RST;
      thr_db_r    <= THR_DB_RST;
      slope_r     <= SLOPE_RST;
    end else begin
      state_r <= state_nxt;
      if (mul_req.start)     pend_r <= 1'b1;
      else if (mul_rsp.done) pend_r <= 1'b0;
      if (state_r == ST_ENV && step) env_r <= env_new;
      if (load_out)              oval_r <= 1'b1;
      else if (out_word.ready)   oval_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BYPASS:    bypass_r    <= cfg_data[0];
          CFG_CHAN_USED: chan_used_r <= cfg_data[1:0];
          CFG_ATTACK:    attack_r    <= cfg_data[15:0];
          CFG_RELEASE:   release_r   <= cfg_data[15:0];
          CFG_THR_LVL:   thr_lvl_r   <= cfg_data;
          CFG_THR_DB:    thr_db_r    <= cfg_data[15:0];
          CFG_SLOPE:     slope_r     <= cfg_data[15:0];
          default:       bypass_r    <= bypass_r;
        endcase
      end
    end
  end

  // Work registers: one step of the current phase per cycle in the shift phases, one per finished product otherwise
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          s0_r   <= in_word.sample_0;
          s1_r   <= in_word.sample_1;
          o0_r   <= in_word.sample_0;
          o1_r   <= in_word.sample_1;
          peak_r <= peak_in;
          gain_r <= 17'(UNITY_GAIN);
          ch_r   <= 1'b0;
        end
      end
      ST_ENV: begin
        if (step) begin
          gain_r <= (env_new <= 32'(ENV_FLOOR)) ? 17'd0 : 17'(UNITY_GAIN);
          y_r    <= env_new;
          p_r    <= 5'd31;
          o1_r   <= '0;
        end
      end
      ST_NORM: begin
        // shift until the leading one reaches the top bit
        if (y_r[31]) begin
          y_r  <= y_r >> 1;
          l2_r <= {pm[5], pm, 16'd0};
          it_r <= 4'd15;
        end else begin
          y_r <= y_r << 1;
          p_r <= p_r - 5'd1;
        end
      end
      ST_SQR: begin
        if (step) begin
          if (sqr_t[31]) begin
            y_r        <= sqr_t >> 1;
            l2_r[it_r] <= 1'b1;
          end else begin
            y_r <= sqr_t;
          end
          it_r <= it_r - 4'd1;
        end
      end
      ST_DB:  if (step) diff_r <= diff_new;
      ST_RED: begin
        if (step) begin
          red_r  <= red_new;
          gain_r <= 17'd0;
        end
      end
      ST_EXP: begin
        if (step) begin
          gain_r <= 17'(UNITY_GAIN);
          n_r    <= 6'(-e_hi);
          f_r    <= e_new[15:0];
          g_r    <= 32'd1 << 30;
          k_r    <= 5'd0;
        end
      end
      ST_FRAC: begin
        // skip clear fraction bits
        if (k_r == 5'd16) begin
          sh_r <= n_r + 6'd14;
        end else if (!f_r[15]) begin
          f_r <= f_r << 1;
          k_r <= k_r + 5'd1;
        end
      end
      ST_GMUL: begin
        if (step) begin
          g_r <= g_new;
          f_r <= f_r << 1;
          k_r <= k_r + 5'd1;
        end
      end
      ST_GSHIFT: begin
        if (sh_r != 6'd0) begin
          g_r  <= g_r >> 1;
          sh_r <= sh_r - 6'd1;
        end else begin
          gain_r <= g_r[16:0];
        end
      end
      ST_OUT: begin
        if (step) begin
          if (ch_r) o1_r <= o_new;
          else      o0_r <= o_new;
          ch_r <= 1'b1;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          os0_r   <= o0_r;
          os1_r   <= o1_r;
          ogain_r <= gain_r;
        end
      end
      default: ch_r <= ch_r;
    endcase
  end

  assign in_word.ready         = (state_r == ST_IDLE);
  assign out_word.valid        = oval_r;
  assign out_word.out_sample_0 = os0_r;
  assign out_word.out_sample_1 = os1_r;
  assign out_word.applied_gain = ogain_r;

  // Checks
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> out_word.applied_gain <= 17'(UNITY_GAIN))
    else $error("applied gain above unity");

  a_bypass_env: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && bypass_r) |=> $stable(env_r))
    else $error("envelope moved in bypass");

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted word lost");
endmodule

### sim/nge_tb_if.sv
// Testbench-side channel interfaces: reuse of nge_in_if / nge_out_if from the RTL.
// This file only holds the per-run knobs shared between sender and receiver.
// Depends on nothing.
interface nge_tb_knobs;
  logic hold_off;
endinterface

### sim/testbench.sv
// Testbench for noise_gate_expander_unit: drives stereo frame words with random
// gaps, predicts envelope, gain and scaled samples, checks each result word.
// Depends on nge_pkg, nge_in_if, nge_out_if, nge_tb_knobs and the block itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nge_pkg::*;

  localparam int SB = 24;
  localparam int LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  nge_in_if  #(.SAMPLE_BITS(SB)) in_ch();
  nge_out_if #(.SAMPLE_BITS(SB)) out_ch();
  nge_tb_knobs knobs();

  noise_gate_expander_unit dut (
    .clk(clk), .rst_n(rst_n), .in_word(in_ch.sink), .out_word(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [23:0] s0;
    logic [23:0] s1;
    logic [16:0] gain;
  } frame_t;

  // predictor copy of registers and envelope
  logic        m_bypass;
  logic [1:0]  m_chans;
  logic [15:0] m_attack, m_release, m_slope;
  logic [31:0] m_thr_lvl;
  logic [15:0] m_thr_db;
  logic [31:0] m_env;
  longint unsigned root_tab [17];

  frame_t expected_words [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // envelope to Q8.8 dB, clamped at the bottom
  function automatic longint level_to_db(logic [31:0] lvl);
    int p;
    longint unsigned y;
    longint l2, db;
    p = 31;
    while (p > 0 && !lvl[p]) p--;
    y = (p <= 30) ? (64'(lvl) << (30 - p)) : (64'(lvl) >> (p - 30));
    l2 = longint'(p - 31) * 65536;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y >>= 1;
        l2 += longint'(1) << i;
      end
    end
    db = floor_div(l2 * DB_PER_LOG2_Q16, 24);
    return (db < DB_MIN_Q8) ? DB_MIN_Q8 : db;
  endfunction

  // Q8.8 dB to Q1.16 linear gain
  function automatic logic [31:0] db_to_linear(longint red);
    longint e, f;
    longint unsigned n, g;
    if (red <= DB_MIN_Q8) return 0;
    e = floor_div(red * LOG2_PER_DB_Q24, 16);
    if (e >= 0) return UNITY_GAIN;
    n = (64'(-e) + 65535) >> 16;
    f = e + longint'(n * 65536);
    g = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if ((f >> (16 - k)) & 1) g = (g * root_tab[k]) >> 30;
    if (n > 40) return 0;
    return 32'(g >> (14 + n));
  endfunction

  function automatic frame_t predict_frame(logic [23:0] a, logic [23:0] b);
    frame_t r;
    longint s [2];
    int nch;
    longint unsigned peak, mag;
    logic [15:0] coeff;
    longint nenv, diff;
    logic [31:0] gain;
    s[0] = longint'(signed'(a));
    s[1] = longint'(signed'(b));
    if (m_bypass) begin
      r.s0 = a;
      r.s1 = b;
      r.gain = 17'(UNITY_GAIN);
      return r;
    end
    nch = (m_chans == 0) ? 1 : ((m_chans > 2) ? 2 : int'(m_chans));
    peak = 0;
    for (int c = 0; c < nch; c++) begin
      mag = 64'(s[c] < 0 ? -s[c] : s[c]) << 8;
      if (mag > peak) peak = mag;
    end
    coeff = (peak > m_env) ? m_attack : m_release;
    nenv = longint'(peak) + floor_div(longint'(coeff) * (longint'(m_env) - longint'(peak)), 16);
    m_env = 32'(nenv);
    if (m_env <= ENV_FLOOR) gain = 0;
    else if (m_env < m_thr_lvl) begin
      diff = level_to_db(m_env) - longint'(signed'(m_thr_db));
      gain = db_to_linear(floor_div(longint'(m_slope) * diff, 16));
    end else gain = UNITY_GAIN;
    r.s0 = 24'(floor_div(s[0] * longint'(gain), 16));
    r.s1 = (nch > 1) ? 24'(floor_div(s[1] * longint'(gain), 16)) : 24'd0;
    r.gain = 17'(gain);
    return r;
  endfunction

  // one write cycle, then cfg_we drops and the predictor copy is updated
  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_BYPASS:    m_bypass = v[0];
      CFG_CHAN_USED: m_chans = v[1:0];
      CFG_ATTACK:    m_attack = v[15:0];
      CFG_RELEASE:   m_release = v[15:0];
      CFG_THR_LVL:   m_thr_lvl = v;
      CFG_THR_DB:    m_thr_db = v[15:0];
      CFG_SLOPE:     m_slope = v[15:0];
      default: ;
    endcase
  endtask

  // drop valid, wait for drain plus the longest path before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (1400) @(posedge clk);
  endtask

  // present one word, record expectation when accepted; valid stays up after
  // acceptance and drops only before a gap
  task automatic send_word(logic [23:0] a, logic [23:0] b, bit check_fixed, frame_t fixed);
    frame_t p;
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_0 <= a;
    in_ch.sample_1 <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = predict_frame(a, b);
    if (check_fixed && p != fixed) begin
      $display("%0t directed row mismatch: expected %h actual predicted %h", $time, fixed, p);
      errors++;
    end
    expected_words.push_back(check_fixed ? fixed : p);
  endtask

  // receiver: random wait per word, and one long hold-off
  initial begin
    int w;
    out_ch.ready = 1'b0;
    knobs.hold_off = 1'b0;
    @(posedge clk);
    forever begin
      if (knobs.hold_off) begin
        w = 3000;
        knobs.hold_off = 1'b0;
      end else begin
        w = $urandom_range(0, 10);
      end
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: actual %h %h %h", $time,
                 out_ch.out_sample_0, out_ch.out_sample_1, out_ch.applied_gain);
        errors++;
      end else begin
        frame_t e;
        e = expected_words.pop_front();
        if (e.s0 !== out_ch.out_sample_0 || e.s1 !== out_ch.out_sample_1 ||
            e.gain !== out_ch.applied_gain) begin
          $display("%0t mismatch: expected %h %h %h actual %h %h %h", $time,
                   e.s0, e.s1, e.gain, out_ch.out_sample_0, out_ch.out_sample_1,
                   out_ch.applied_gain);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || stim_done)
      idle_cycles <= 0;
    else if (rst_n && (in_ch.valid || expected_words.size() != 0))
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("[noise_gate_expander_unit] ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [23:0] a;
    logic [23:0] b;
    bit fixed;
    frame_t res;
  } stim_row_t;

  stim_row_t rows [$];

  function automatic logic [23:0] rand_sample(int phase);
    case (phase % 4)
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 2000)) ^ {24{$urandom_range(0, 1) == 1}};
      2: return 24'($urandom_range(0, 200000)) ^ {24{$urandom_range(0, 1) == 1}};
      default: return 24'($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
    endcase
  endfunction

  initial begin
    frame_t z;
    root_tab[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) root_tab[k] = int_sqrt(root_tab[k - 1] << 30);
    in_ch.valid = 1'b0;
    in_ch.sample_0 = '0;
    in_ch.sample_1 = '0;
    m_bypass = BYPASS_RST; m_chans = CHAN_USED_RST; m_attack = ATTACK_RST;
    m_release = RELEASE_RST; m_thr_lvl = THR_LVL_RST; m_thr_db = THR_DB_RST;
    m_slope = SLOPE_RST; m_env = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: zeros after reset gate to zero, then extremes, small values, bit patterns and zeros
    z = '0;
    rows.push_back('{24'd0, 24'd0, 1'b1, z});
    rows.push_back('{24'd0, 24'd0, 1'b1, z});
    rows.push_back('{24'h7FFFFF, 24'h800000, 1'b0, z});
    rows.push_back('{24'h800000, 24'h7FFFFF, 1'b0, z});
    rows.push_back('{24'd1, 24'hFFFFFF, 1'b0, z});
    rows.push_back('{24'h000100, 24'hFFFF00, 1'b0, z});
    rows.push_back('{24'h555555, 24'hAAAAAA, 1'b0, z});
    rows.push_back('{24'd0, 24'd0, 1'b0, z});
    rows.push_back('{24'd0, 24'd0, 1'b0, z});
    foreach (rows[i]) send_word(rows[i].a, rows[i].b, rows[i].fixed, rows[i].res);

    // bypass: words pass through with unity gain
    drain();
    write_reg(CFG_BYPASS, 32'd1);
    z.s0 = 24'h800000; z.s1 = 24'h7FFFFF; z.gain = 17'(UNITY_GAIN);
    send_word(24'h800000, 24'h7FFFFF, 1'b1, z);
    z.s0 = 24'h123456; z.s1 = 24'hFEDCBA;
    send_word(24'h123456, 24'hFEDCBA, 1'b1, z);
    drain();
    write_reg(CFG_BYPASS, 32'd0);

    // channel counts 0 to 3: single channel, two channels and out-of-range counts
    for (int ch = 0; ch < 4; ch++) begin
      drain();
      write_reg(CFG_CHAN_USED, 32'(ch));
      for (int i = 0; i < 3; i++) send_word(rand_sample(i + 1), 24'h7FFFFF, 1'b0, z);
    end

    // random phases with varied settings, extremes included
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      write_reg(CFG_CHAN_USED, 32'($urandom_range(0, 3)));
      write_reg(CFG_ATTACK, ph == 0 ? 32'd0 : (ph == 1 ? 32'd65535 : 32'($urandom_range(0, 65535))));
      write_reg(CFG_RELEASE, ph == 0 ? 32'd65535 : (ph == 1 ? 32'd0 : 32'($urandom_range(0, 65535))));
      write_reg(CFG_THR_LVL, ph == 0 ? 32'h80000000 : (ph == 1 ? 32'd0 : 32'($urandom)));
      write_reg(CFG_THR_DB, ph == 0 ? 32'(DB_MIN_Q8) : (ph == 1 ? 32'd0 :
                32'(-$urandom_range(0, 25600))));
      write_reg(CFG_SLOPE, ph == 0 ? 32'd65535 : (ph == 1 ? 32'd0 : 32'($urandom_range(0, 65535))));
      write_reg(CFG_BYPASS, 32'($urandom_range(0, 5) == 0));
      if (ph == 4) knobs.hold_off = 1'b1;
      for (int i = 0; i < 48; i++)
        send_word(rand_sample(i + ph), rand_sample(i * 3 + ph), 1'b0, z);
    end

    // drop valid, wait for the tail, then settle
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    stim_done = 1'b1;
    repeat (1400) @(posedge clk);
    if (errors == 0)
      $display("[noise_gate_expander_unit] OK");
    else
      $display("[noise_gate_expander_unit] ERROR");
    $finish;
  end
endmodule

### files.f
hdl/nge_pkg.sv
hdl/nge_in_if.sv
hdl/nge_out_if.sv
hdl/nge_serial_mult.sv
hdl/noise_gate_expander_unit.sv
sim/nge_tb_if.sv
sim/testbench.sv
